@@ rtl/e2k_pkg.sv @@
// Package for the equinoctial-to-Keplerian converter.
// Holds datapath widths, CORDIC arctangent table and the vector type.
// No dependencies.
package e2k_pkg;

  localparam int CORDIC_STEPS_DEF  = 30;
  localparam int FRACTION_BITS_DEF = 28;
  localparam int GUARD             = 8;
  localparam int XW                = 44;  // CORDIC x/y width, guard-scaled
  localparam int ZW                = 34;  // angle accumulator, signed
  localparam int MW                = 36;  // compensated magnitude width
  localparam logic [31:0] INV_GAIN = 32'd2608131496;
  localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'sd2147483648);
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

endpackage

@@ rtl/e2k_if.sv @@
// Channel interfaces for the converter: element set in, Keplerian set out.
// No dependencies.
interface e2k_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] ecc_sin_part;
  logic [31:0] ecc_cos_part;
  logic [31:0] tilt_sin_part;
  logic [31:0] tilt_cos_part;
  logic [31:0] mean_longitude;
  modport source (output valid, ecc_sin_part, ecc_cos_part, tilt_sin_part,
                  tilt_cos_part, mean_longitude, input ready);
  modport sink   (input valid, ecc_sin_part, ecc_cos_part, tilt_sin_part,
                  tilt_cos_part, mean_longitude, output ready);
endinterface

interface e2k_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] eccentricity;
  logic [31:0] inclination;
  logic [31:0] node_longitude;
  logic [31:0] periapsis_argument;
  logic [31:0] mean_anomaly;
  modport source (output valid, eccentricity, inclination, node_longitude,
                  periapsis_argument, mean_anomaly, input ready);
  modport sink   (input valid, eccentricity, inclination, node_longitude,
                  periapsis_argument, mean_anomaly, output ready);
endinterface

@@ rtl/equinoctial_to_keplerian.sv @@
// Equinoctial to Keplerian element conversion, fully pipelined CORDIC rows.
// Throughput one element set per cycle; the whole pipeline stalls only while
// a finished result is held. Reset (rst_n, synchronous) clears the valid bits.
// Depends on e2k_pkg, e2k_if, e2k_cordic_chain, e2k_gain.
module equinoctial_to_keplerian #(
  parameter int CORDIC_STEPS  = e2k_pkg::CORDIC_STEPS_DEF,
  parameter int FRACTION_BITS = e2k_pkg::FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  e2k_in_if.sink    in_ch,
  e2k_out_if.source out_ch
);
  import e2k_pkg::*;

  localparam int NV  = 2 * CORDIC_STEPS + 4;
  localparam int DL  = 2 * CORDIC_STEPS + 3;
  localparam int DA  = CORDIC_STEPS + 3;
  localparam int DE  = CORDIC_STEPS;

  logic    en;
  logic    out_valid_r;
  logic [NV-1:0] vld_r;

  cordic_t vec_e_nxt, vec_t_nxt, vec_e_r, vec_t_r;
  cordic_t chn_e, chn_t, inc_in, inc_out;
  logic [31:0] lam_r;
  logic        zero_e_r, zero_t_r;
  logic signed [XW-1:0] xk, yh, xq, yp;

  logic [MW-1:0] mag_e, mag_t;

  logic [31:0] lam_d  [DL];
  logic        zer_e_d[DL];
  logic        zer_t_d[DL];
  logic [31:0] ang_e_d[DA];
  logic [31:0] ang_t_d[DA];
  logic [MW-1:0] ecc_d[DE];

  logic signed [ZW-1:0] zc;
  logic [31:0] node, peri;
  logic [31:0] ecc_r, inc_r, node_r, arg_r, anom_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  assign xk = XW'($signed(in_ch.ecc_cos_part))  <<< GUARD;
  assign yh = XW'($signed(in_ch.ecc_sin_part))  <<< GUARD;
  assign xq = XW'($signed(in_ch.tilt_cos_part)) <<< GUARD;
  assign yp = XW'($signed(in_ch.tilt_sin_part)) <<< GUARD;

  always_comb begin
    vec_e_nxt = '{x: xk, y: yh, z: '0};
    if (xk < 0) begin
      vec_e_nxt = '{x: -xk, y: -yh, z: HALF_TURN};
    end
    vec_t_nxt = '{x: xq, y: yp, z: '0};
    if (xq < 0) begin
      vec_t_nxt = '{x: -xq, y: -yp, z: HALF_TURN};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_e_r  <= vec_e_nxt;
      vec_t_r  <= vec_t_nxt;
      lam_r    <= in_ch.mean_longitude;
      zero_e_r <= (in_ch.ecc_cos_part == '0) && (in_ch.ecc_sin_part == '0);
      zero_t_r <= (in_ch.tilt_cos_part == '0) && (in_ch.tilt_sin_part == '0);
    end
  end

  e2k_cordic_chain #(.STEPS(CORDIC_STEPS)) u_chain_e (
    .clk(clk), .en(en), .din(vec_e_r), .dout(chn_e));
  e2k_cordic_chain #(.STEPS(CORDIC_STEPS)) u_chain_t (
    .clk(clk), .en(en), .din(vec_t_r), .dout(chn_t));

  e2k_gain u_gain_e (.clk(clk), .en(en), .x(chn_e.x), .mag(mag_e));
  e2k_gain u_gain_t (.clk(clk), .en(en), .x(chn_t.x), .mag(mag_t));

  // atan(r) as the angle of (1.0, r)
  assign inc_in.x = XW'(1) <<< (FRACTION_BITS + GUARD);
  assign inc_in.y = $signed(XW'({mag_t, {GUARD{1'b0}}}));
  assign inc_in.z = '0;

  e2k_cordic_chain #(.STEPS(CORDIC_STEPS)) u_chain_i (
    .clk(clk), .en(en), .din(inc_in), .dout(inc_out));

  always_ff @(posedge clk) begin
    if (en) begin
      lam_d[0]   <= lam_r;
      zer_e_d[0] <= zero_e_r;
      zer_t_d[0] <= zero_t_r;
      for (int i = 1; i < DL; i++) begin
        lam_d[i]   <= lam_d[i-1];
        zer_e_d[i] <= zer_e_d[i-1];
        zer_t_d[i] <= zer_t_d[i-1];
      end
      ang_e_d[0] <= chn_e.z[31:0];
      ang_t_d[0] <= chn_t.z[31:0];
      for (int i = 1; i < DA; i++) begin
        ang_e_d[i] <= ang_e_d[i-1];
        ang_t_d[i] <= ang_t_d[i-1];
      end
      ecc_d[0] <= mag_e;
      for (int i = 1; i < DE; i++) begin
        ecc_d[i] <= ecc_d[i-1];
      end
    end
  end

  always_comb begin
    zc = inc_out.z;
    if (zc < 0) begin
      zc = '0;
    end
    if (zc > QUARTER_TURN) begin
      zc = QUARTER_TURN;
    end
    node = zer_t_d[DL-1] ? '0 : ang_t_d[DA-1];
    peri = zer_e_d[DL-1] ? '0 : ang_e_d[DA-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ecc_r  <= (ecc_d[DE-1] > MW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ecc_d[DE-1][31:0];
      inc_r  <= {zc[30:0], 1'b0};
      node_r <= node;
      arg_r  <= peri - node;
      anom_r <= lam_d[DL-1] - peri;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NV-2:0], in_ch.valid};
      out_valid_r <= vld_r[NV-1];
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.eccentricity       = ecc_r;
  assign out_ch.inclination        = inc_r;
  assign out_ch.node_longitude     = node_r;
  assign out_ch.periapsis_argument = arg_r;
  assign out_ch.mean_anomaly       = anom_r;

  a_incl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> inc_r <= 32'h8000_0000)
    else $error("inclination beyond half turn");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && (vld_r == '0))
    else $error("valid bits survive reset");

endmodule

@@ rtl/e2k_cordic_cell.sv @@
// One registered vectoring CORDIC micro-rotation.
// Depends on e2k_pkg.
module e2k_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic            clk,
  input  logic            en,
  input  e2k_pkg::cordic_t din,
  output e2k_pkg::cordic_t dout
);
  import e2k_pkg::*;

  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] da;
  cordic_t              nxt;
  cordic_t              dout_r;

  assign dx = din.y >>> SHIFT;
  assign dy = din.x >>> SHIFT;
  assign da = $signed({{(ZW-32){1'b0}}, ATAN_TURNS[SHIFT]});

  always_comb begin
    if (din.y >= 0) begin
      nxt.x = din.x + dx;
      nxt.y = din.y - dy;
      nxt.z = din.z + da;
    end else begin
      nxt.x = din.x - dx;
      nxt.y = din.y + dy;
      nxt.z = din.z - da;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= nxt;
    end
  end

  assign dout = dout_r;
endmodule

@@ rtl/e2k_cordic_chain.sv @@
// Row of CORDIC cells, one micro-rotation per stage.
// Depends on e2k_pkg, e2k_cordic_cell.
module e2k_cordic_chain #(
  parameter int STEPS = e2k_pkg::CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            en,
  input  e2k_pkg::cordic_t din,
  output e2k_pkg::cordic_t dout
);
  import e2k_pkg::*;

  cordic_t link [STEPS+1];

  assign link[0] = din;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    e2k_cordic_cell #(.SHIFT(i)) u_cell (
      .clk (clk),
      .en  (en),
      .din (link[i]),
      .dout(link[i+1])
    );
  end

  assign dout = link[STEPS];
endmodule

@@ rtl/e2k_gain.sv @@
// CORDIC gain compensation: floor(x * INV_GAIN / 2^32), then guard rounding.
// Three stages: split partial products, sum, round. Depends on e2k_pkg.
module e2k_gain (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [e2k_pkg::XW-1:0] x,
  output logic [e2k_pkg::MW-1:0]     mag
);
  import e2k_pkg::*;

  localparam int LW = 22;
  localparam int HW = XW - 1 - LW;

  logic [XW-2:0]          xu;
  logic [LW+31:0]         plo_r;
  logic [HW+31:0]         phi_r;
  logic [XW+31:0]         sum;
  logic [XW-2:0]          hi_r;
  logic [XW-1:0]          rnd;
  logic [MW-1:0]          mag_r;

  assign xu  = (x < 0) ? '0 : x[XW-2:0];
  assign sum = {phi_r, {LW{1'b0}}} + {{(XW-LW){1'b0}}, plo_r};
  assign rnd = {1'b0, hi_r} + XW'(1 << (GUARD - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r <= xu[LW-1:0] * INV_GAIN;
      phi_r <= xu[XW-2:LW] * INV_GAIN;
      hi_r  <= sum[XW+30:32];
      mag_r <= rnd[GUARD+MW-1:GUARD];
    end
  end

  assign mag = mag_r;
endmodule
